FILE: rtl/pen_pkg.sv
// Package for the plane equation normalize core.
// Holds the fixed number formats, derived widths and the cell bus types; no dependencies.
package pen_pkg;

    localparam int unsigned COORD_BITS     = 16;
    localparam int unsigned NORM_FRAC_BITS = 14;
    localparam int unsigned D_FRAC_BITS    = 4;
    localparam int unsigned QBITS          = 24;
    localparam int unsigned LANES          = 4;
    localparam int unsigned NUM_COORDS     = 9;

    localparam int unsigned LANE_A = 0;
    localparam int unsigned LANE_B = 1;
    localparam int unsigned LANE_C = 2;
    localparam int unsigned LANE_D = 3;

    localparam int unsigned DIFF_W = COORD_BITS + 1;
    localparam int unsigned PROD_W = 2 * DIFF_W;
    localparam int unsigned N_W    = PROD_W + 1;
    localparam int unsigned NL_W   = N_W / 2;
    localparam int unsigned NH_W   = N_W - NL_W;
    localparam int unsigned L2_W   = 2 * N_W;
    localparam int unsigned DP_W   = N_W + COORD_BITS;
    localparam int unsigned D_W    = DP_W + 2;
    localparam int unsigned DL_W   = D_W / 2;
    localparam int unsigned DH_W   = D_W - DL_W;
    localparam int unsigned DSQ_W  = 2 * D_W;
    localparam int unsigned T_W    = L2_W + QBITS + 3;
    localparam int unsigned R_W    = L2_W + 2 * QBITS + 6;

    typedef struct packed {
        logic signed [R_W-1:0] rem;
        logic signed [T_W-1:0] acc;
        logic [QBITS-1:0]      quo;
        logic                  neg;
    } t_lane;

    typedef struct packed {
        logic                  vld;
        logic                  degen;
        logic [L2_W-1:0]       len2;
        t_lane [LANES-1:0]     lane;
    } t_cell_bus;

endpackage

FILE: rtl/pen_front.sv
// Front pipeline of the plane equation core: normal, offset, squared length, cell seeds.
// Depends on pen_pkg.
module pen_front (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_en,
    input  logic                                                  i_vld,
    input  logic                                                  i_mode,
    input  logic [pen_pkg::NUM_COORDS-1:0][pen_pkg::COORD_BITS-1:0] i_coord,
    output pen_pkg::t_cell_bus                                    o_bus
);
    import pen_pkg::*;

    localparam int unsigned NSTG = 7;

    logic [NSTG-1:0] r_vld;

    logic                          r1_mode;
    logic signed [COORD_BITS-1:0]  r1_p [3];
    logic signed [COORD_BITS-1:0]  r1_nrm [3];
    logic signed [DIFF_W-1:0]      r1_u [3];
    logic signed [DIFF_W-1:0]      r1_v [3];

    logic                          r2_mode;
    logic signed [COORD_BITS-1:0]  r2_p [3];
    logic signed [COORD_BITS-1:0]  r2_nrm [3];
    logic signed [PROD_W-1:0]      r2_pa [3];
    logic signed [PROD_W-1:0]      r2_pb [3];

    logic signed [COORD_BITS-1:0]  r3_p [3];
    logic signed [N_W-1:0]         r3_n [3];

    logic signed [DP_W-1:0]        r4_dp [3];
    logic [2*NH_W-1:0]             r4_hh [3];
    logic [NH_W+NL_W-1:0]          r4_hl [3];
    logic [2*NL_W-1:0]             r4_ll [3];
    logic                          r4_neg [3];

    logic [L2_W-1:0]               r5_nsq [3];
    logic signed [D_W-1:0]         r5_d;
    logic                          r5_neg [3];

    logic [L2_W-1:0]               r6_nsq [3];
    logic [L2_W-1:0]               r6_len2;
    logic [2*DH_W-1:0]             r6_dhh;
    logic [DH_W+DL_W-1:0]          r6_dhl;
    logic [2*DL_W-1:0]             r6_dll;
    logic                          r6_dneg;
    logic                          r6_neg [3];

    logic [L2_W-1:0]               r7_nsq [3];
    logic [L2_W-1:0]               r7_len2;
    logic [DSQ_W-1:0]              r7_dsq;
    logic                          r7_dneg;
    logic                          r7_neg [3];

    t_cell_bus                     r_bus;

    logic [N_W-1:0]                w_nmag [3];
    logic [D_W-1:0]                w_dmag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nmag[i] = r3_n[i][N_W-1] ? N_W'(-r3_n[i]) : N_W'(r3_n[i]);
        end
        w_dmag = r5_d[D_W-1] ? D_W'(-r5_d) : D_W'(r5_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_bus.vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};

            // Edge vectors from the first point.
            r1_mode <= i_mode;
            for (int i = 0; i < 3; i++) begin
                r1_p[i]   <= $signed(i_coord[i]);
                r1_nrm[i] <= $signed(i_coord[3+i]);
                r1_u[i]   <= DIFF_W'($signed(i_coord[3+i])) - DIFF_W'($signed(i_coord[i]));
                r1_v[i]   <= DIFF_W'($signed(i_coord[6+i])) - DIFF_W'($signed(i_coord[i]));
            end

            // Cross product terms.
            r2_mode <= r1_mode;
            for (int i = 0; i < 3; i++) begin
                r2_p[i]   <= r1_p[i];
                r2_nrm[i] <= r1_nrm[i];
                r2_pa[i]  <= PROD_W'(r1_u[(i+1)%3]) * PROD_W'(r1_v[(i+2)%3]);
                r2_pb[i]  <= PROD_W'(r1_u[(i+2)%3]) * PROD_W'(r1_v[(i+1)%3]);
            end

            for (int i = 0; i < 3; i++) begin
                r3_p[i] <= r2_p[i];
                r3_n[i] <= r2_mode ? N_W'(r2_nrm[i]) : N_W'(r2_pa[i]) - N_W'(r2_pb[i]);
            end

            // Dot product terms and split squares of the normal.
            for (int i = 0; i < 3; i++) begin
                r4_dp[i]  <= DP_W'(r3_n[i]) * DP_W'(r3_p[i]);
                r4_hh[i]  <= (2*NH_W)'(w_nmag[i][N_W-1:NL_W]) * (2*NH_W)'(w_nmag[i][N_W-1:NL_W]);
                r4_hl[i]  <= (NH_W+NL_W)'(w_nmag[i][N_W-1:NL_W])
                           * (NH_W+NL_W)'(w_nmag[i][NL_W-1:0]);
                r4_ll[i]  <= (2*NL_W)'(w_nmag[i][NL_W-1:0]) * (2*NL_W)'(w_nmag[i][NL_W-1:0]);
                r4_neg[i] <= r3_n[i][N_W-1];
            end

            for (int i = 0; i < 3; i++) begin
                r5_nsq[i] <= (L2_W'(r4_hh[i]) << (2*NL_W)) + (L2_W'(r4_hl[i]) << (NL_W+1))
                           + L2_W'(r4_ll[i]);
                r5_neg[i] <= r4_neg[i];
            end
            r5_d <= -(D_W'(r4_dp[0]) + D_W'(r4_dp[1]) + D_W'(r4_dp[2]));

            // Squared length and split square of the offset.
            r6_len2 <= r5_nsq[0] + r5_nsq[1] + r5_nsq[2];
            r6_dhh  <= (2*DH_W)'(w_dmag[D_W-1:DL_W]) * (2*DH_W)'(w_dmag[D_W-1:DL_W]);
            r6_dhl  <= (DH_W+DL_W)'(w_dmag[D_W-1:DL_W]) * (DH_W+DL_W)'(w_dmag[DL_W-1:0]);
            r6_dll  <= (2*DL_W)'(w_dmag[DL_W-1:0]) * (2*DL_W)'(w_dmag[DL_W-1:0]);
            r6_dneg <= r5_d[D_W-1];
            for (int i = 0; i < 3; i++) begin
                r6_nsq[i] <= r5_nsq[i];
                r6_neg[i] <= r5_neg[i];
            end

            r7_dsq  <= (DSQ_W'(r6_dhh) << (2*DL_W)) + (DSQ_W'(r6_dhl) << (DL_W+1))
                     + DSQ_W'(r6_dll);
            r7_len2 <= r6_len2;
            r7_dneg <= r6_dneg;
            for (int i = 0; i < 3; i++) begin
                r7_nsq[i] <= r6_nsq[i];
                r7_neg[i] <= r6_neg[i];
            end

            // Seed the cells: remainder X^2 - len2 for a trial odd number of -1.
            r_bus.vld   <= r_vld[NSTG-1];
            r_bus.degen <= (r7_len2 == '0);
            r_bus.len2  <= r7_len2;
            for (int i = 0; i < 3; i++) begin
                r_bus.lane[i].rem <= $signed(R_W'(r7_nsq[i]) << (2*NORM_FRAC_BITS+2))
                                   - $signed(R_W'(r7_len2));
                r_bus.lane[i].acc <= -$signed(T_W'(r7_len2));
                r_bus.lane[i].quo <= '0;
                r_bus.lane[i].neg <= r7_neg[i];
            end
            r_bus.lane[LANE_D].rem <= $signed(R_W'(r7_dsq) << (2*D_FRAC_BITS+2))
                                    - $signed(R_W'(r7_len2));
            r_bus.lane[LANE_D].acc <= -$signed(T_W'(r7_len2));
            r_bus.lane[LANE_D].quo <= '0;
            r_bus.lane[LANE_D].neg <= r7_dneg;
        end
    end

    assign o_bus = r_bus;

endmodule

FILE: rtl/pen_cell.sv
// One cell of the quotient chain: settles one bit of all four rounded quotients.
// Depends on pen_pkg.
module pen_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  pen_pkg::t_cell_bus i_bus,
    output pen_pkg::t_cell_bus o_bus
);
    import pen_pkg::*;

    t_cell_bus             r_bus;
    t_cell_bus             n_bus;
    logic signed [R_W-1:0] w_cand [LANES];

    // With m the current odd trial value, the remainder is X^2 - m^2*len2 and
    // acc is m*len2; raising m by 2^(BIT+1) needs only shifts and adds.
    always_comb begin
        n_bus = i_bus;
        for (int k = 0; k < LANES; k++) begin
            w_cand[k] = i_bus.lane[k].rem
                      - (R_W'(i_bus.lane[k].acc) <<< (BIT+2))
                      - $signed(R_W'(i_bus.len2) << (2*BIT+2));
            if (!w_cand[k][R_W-1]) begin
                n_bus.lane[k].rem = w_cand[k];
                n_bus.lane[k].acc = i_bus.lane[k].acc + $signed(T_W'(i_bus.len2) << (BIT+1));
                n_bus.lane[k].quo = i_bus.lane[k].quo | (QBITS'(1) << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

FILE: rtl/plane_equation_normalize_core.sv
// Top level of the plane equation normalize core: front pipeline, quotient cell chain,
// output rounding and skid buffer. Depends on pen_pkg, pen_front and pen_cell.
//
//   Channel | Direction | Ports              | Word contents
//   --------+-----------+--------------------+---------------------------------------
//   s       | in        | i_s_t*, o_s_tready | nine signed coordinates, mode in tuser
//   m       | out       | o_m_t*, i_m_tready | coefficients a, b, c, d, flag in tuser
//
// One word is accepted per cycle while o_s_tready is high; each word passes through
// 7 front stages, one seed stage, 24 quotient cells and the output register, and leaves
// when the output side is ready. Each of the 24 cells resolves one quotient bit of all four
// coefficients. Reset (synchronous, active low) clears only the valid bits.
// A stalled output parks one word in a skid register; tready drops only when it is full,
// and the whole pipeline then holds.
module plane_equation_normalize_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,   // x0, y0, z0, x1, y1, z1, x2, y2, z2 (16 bits each)
    input  logic         i_s_tuser,   // mode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,   // coef_a, coef_b, coef_c (16 each), coef_d (21), zero pad
    output logic         o_m_tuser    // degenerate
);
    import pen_pkg::*;

    localparam int unsigned ABC_W  = 16;
    localparam int unsigned D_OUT_W = 21;
    localparam int unsigned ODATA_W = 72;

    // Signed result of a rounded magnitude, clipped to a b-bit signed range.
    function automatic logic signed [QBITS:0] f_clip(input logic [QBITS-1:0] q,
                                                     input logic neg,
                                                     input int unsigned b);
        logic [QBITS:0] lim;
        logic [QBITS:0] qx;
        logic [QBITS:0] res;
        lim = (QBITS+1)'(1) << (b - 1);
        qx  = {1'b0, q};
        if (neg) begin
            res = (qx > lim) ? -lim : -qx;
        end else begin
            res = (qx >= lim) ? (lim - (QBITS+1)'(1)) : qx;
        end
        return $signed(res);
    endfunction

    logic                en;
    t_cell_bus           w_bus [QBITS+1];
    logic signed [QBITS:0] w_val [LANES];
    logic [ODATA_W-1:0]  w_tdata;

    logic                r_out_vld;
    logic [ODATA_W-1:0]  r_out_data;
    logic                r_out_degen;
    logic                r_skid_vld;
    logic [ODATA_W-1:0]  r_skid_data;
    logic                r_skid_degen;

    // The pipeline moves whenever the skid register has room.
    assign en         = !r_skid_vld;
    assign o_s_tready = en;

    pen_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_mode  (i_s_tuser),
        .i_coord (i_s_tdata),
        .o_bus   (w_bus[0])
    );

    // Cell k decides quotient bit QBITS-1-k, most significant first.
    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        pen_cell #(
            .BIT (QBITS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (w_bus[k]),
            .o_bus   (w_bus[k+1])
        );
    end

    // Apply signs and clip; a zero-length normal forces every coefficient to zero.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_val[k] = f_clip(w_bus[QBITS].lane[k].quo, w_bus[QBITS].lane[k].neg,
                              (k == LANE_D) ? D_OUT_W : ABC_W);
        end
        w_tdata = {(ODATA_W-3*ABC_W-D_OUT_W)'(0),
                   w_val[LANE_D][D_OUT_W-1:0],
                   w_val[LANE_C][ABC_W-1:0],
                   w_val[LANE_B][ABC_W-1:0],
                   w_val[LANE_A][ABC_W-1:0]};
        if (w_bus[QBITS].degen) begin
            w_tdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (en) begin
            if (!r_out_vld || i_m_tready) begin
                r_out_vld   <= w_bus[QBITS].vld;
                r_out_data  <= w_tdata;
                r_out_degen <= w_bus[QBITS].degen;
            end else if (w_bus[QBITS].vld) begin
                r_skid_vld   <= 1'b1;
                r_skid_data  <= w_tdata;
                r_skid_degen <= w_bus[QBITS].degen;
            end
        end else if (i_m_tready) begin
            // Output register is full here; refill it from the skid word.
            r_out_data  <= r_skid_data;
            r_out_degen <= r_skid_degen;
            r_skid_vld  <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_degen;

endmodule
